// File: src/ter_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ter_pkg;

  // Tile geometry and field widths.
  localparam int TILE_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 32;
  localparam int MASK_W    = 64;

  // Signed widths of the edge arithmetic.
  localparam int DELTA_W = COORD_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int EDGE_W  = PROD_W + 1;

  localparam logic [COORD_W:0] TILE_MAX = (COORD_W + 1)'(TILE_SIZE - 1);

  // Input transaction: one triangle and its color.
  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by_coord;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COLOR_W-1:0] fill_color;
  } in_t;

  // Result transaction: one bounding-box row.
  typedef struct packed {
    logic [COORD_W-1:0] row_y;
    logic [COORD_W-1:0] span_left;
    logic [MASK_W-1:0]  coverage_mask;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_row;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } vertex_t;

  typedef vertex_t [2:0] tri_t;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
  } box_t;

  // Operations of the shared edge unit.
  typedef enum logic [2:0] {
    EOP_HOLD,
    EOP_MUL,
    EOP_SUB,
    EOP_STEPX,
    EOP_STEPY
  } edge_op_t;

  typedef struct packed {
    edge_op_t   op;
    logic [1:0] sel;
  } edge_ctl_t;

  // Coordinates beyond the tile saturate to its last pixel.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    r = v;
    if ({1'b0, v} > TILE_MAX) begin
      r = TILE_MAX[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/ter_edge_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module ter_edge_unit
  import ter_pkg::*;
(
  input  wire logic      clk,
  input  wire edge_ctl_t ctl,
  input  wire tri_t      verts,
  input  wire box_t      box,
  output logic           covered
);

  logic signed [EDGE_W-1:0]  e_cur_r  [3];
  logic signed [EDGE_W-1:0]  e_row_r  [3];
  logic signed [DELTA_W-1:0] step_x_r [3];
  logic signed [DELTA_W-1:0] step_y_r [3];
  logic signed [PROD_W-1:0]  prod_a_r;
  logic signed [PROD_W-1:0]  prod_b_r;
  logic signed [DELTA_W-1:0] dx_r;
  logic signed [DELTA_W-1:0] dy_r;

  vertex_t                   p0;
  vertex_t                   p1;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [DELTA_W-1:0] rel_x;
  logic signed [DELTA_W-1:0] rel_y;
  logic signed [EDGE_W-1:0]  e_init;
  logic [2:0]                nonneg;
  logic [2:0]                nonpos;

  // Pick the two end points of the selected edge.
  always_comb begin
    unique case (ctl.sel)
      2'd0: begin
        p0 = verts[0];
        p1 = verts[1];
      end
      2'd1: begin
        p0 = verts[1];
        p1 = verts[2];
      end
      default: begin
        p0 = verts[2];
        p1 = verts[0];
      end
    endcase
  end

  // Edge direction and the box corner relative to the edge start.
  assign dx    = signed'({1'b0, p1.x}) - signed'({1'b0, p0.x});
  assign dy    = signed'({1'b0, p1.y}) - signed'({1'b0, p0.y});
  assign rel_x = signed'({1'b0, box.min_x}) - signed'({1'b0, p0.x});
  assign rel_y = signed'({1'b0, box.min_y}) - signed'({1'b0, p0.y});

  assign e_init = EDGE_W'(prod_a_r) - EDGE_W'(prod_b_r);

  // The multiply, subtract and incremental steps share these registers.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      EOP_MUL: begin
        prod_a_r <= PROD_W'(dx * rel_y);
        prod_b_r <= PROD_W'(dy * rel_x);
        dx_r     <= dx;
        dy_r     <= dy;
      end
      EOP_SUB: begin
        e_row_r[ctl.sel]  <= e_init;
        e_cur_r[ctl.sel]  <= e_init;
        step_x_r[ctl.sel] <= -dy_r;
        step_y_r[ctl.sel] <= dx_r;
      end
      EOP_STEPX: begin
        for (int i = 0; i < 3; i++) begin
          e_cur_r[i] <= e_cur_r[i] + EDGE_W'(step_x_r[i]);
        end
      end
      EOP_STEPY: begin
        for (int i = 0; i < 3; i++) begin
          e_row_r[i] <= e_row_r[i] + EDGE_W'(step_y_r[i]);
          e_cur_r[i] <= e_row_r[i] + EDGE_W'(step_y_r[i]);
        end
      end
      default: begin
      end
    endcase
  end

  // A pixel is covered when all edges agree in sign; a zero edge value matches either sign.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nonneg[i] = !e_cur_r[i][EDGE_W-1];
      nonpos[i] = e_cur_r[i][EDGE_W-1] || (e_cur_r[i] == '0);
    end
    covered = (&nonneg) || (&nonpos);
  end

endmodule

`default_nettype wire

// File: src/ter_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ter_ctrl
  import ter_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire in_t   in_data,
  input  wire logic  covered,
  output logic       busy,
  output edge_ctl_t  ctl,
  output tri_t       verts,
  output box_t       box,
  output logic       out_valid,
  output out_t       out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOX,
    S_MUL,
    S_SUB,
    S_WALK
  } state_t;

  state_t             state_r;
  logic [1:0]         sel_r;
  tri_t               verts_r;
  box_t               box_r;
  logic [COLOR_W-1:0] color_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [MASK_W-1:0]  mask_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [COORD_W-1:0] min_x;
  logic [COORD_W-1:0] max_x;
  logic [COORD_W-1:0] min_y;
  logic [COORD_W-1:0] max_y;
  logic [COORD_W-1:0] col;
  logic [MASK_W-1:0]  mask_full;
  logic               row_end;

  assign busy      = (state_r != S_IDLE);
  assign verts     = verts_r;
  assign box       = box_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Bounding box of the latched vertices.
  always_comb begin
    min_x = (verts_r[0].x < verts_r[1].x) ? verts_r[0].x : verts_r[1].x;
    min_x = (min_x < verts_r[2].x) ? min_x : verts_r[2].x;
    max_x = (verts_r[0].x > verts_r[1].x) ? verts_r[0].x : verts_r[1].x;
    max_x = (max_x > verts_r[2].x) ? max_x : verts_r[2].x;
    min_y = (verts_r[0].y < verts_r[1].y) ? verts_r[0].y : verts_r[1].y;
    min_y = (min_y < verts_r[2].y) ? min_y : verts_r[2].y;
    max_y = (verts_r[0].y > verts_r[1].y) ? verts_r[0].y : verts_r[1].y;
    max_y = (max_y > verts_r[2].y) ? max_y : verts_r[2].y;
  end

  // Coverage of the current pixel merged into the row mask.
  assign col       = x_r - box_r.min_x;
  assign mask_full = mask_r | (covered ? (MASK_W'(1) << col) : '0);
  assign row_end   = (x_r == box_r.max_x);

  // Command to the edge unit.
  always_comb begin
    ctl.sel = sel_r;
    unique case (state_r)
      S_MUL:   ctl.op = EOP_MUL;
      S_SUB:   ctl.op = EOP_SUB;
      S_WALK:  ctl.op = row_end ? EOP_STEPY : EOP_STEPX;
      default: ctl.op = EOP_HOLD;
    endcase
  end

  // Sequencer: latch, box, a setup for each edge, then one pixel per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            verts_r[0].x <= clamp_coord(in_data.ax);
            verts_r[0].y <= clamp_coord(in_data.ay);
            verts_r[1].x <= clamp_coord(in_data.bx);
            verts_r[1].y <= clamp_coord(in_data.by_coord);
            verts_r[2].x <= clamp_coord(in_data.cx);
            verts_r[2].y <= clamp_coord(in_data.cy);
            color_r      <= in_data.fill_color;
            state_r      <= S_BOX;
          end
        end
        S_BOX: begin
          box_r.min_x <= min_x;
          box_r.max_x <= max_x;
          box_r.min_y <= min_y;
          box_r.max_y <= max_y;
          sel_r       <= '0;
          state_r     <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_SUB;
        end
        S_SUB: begin
          if (sel_r == 2'd2) begin
            x_r     <= box_r.min_x;
            y_r     <= box_r.min_y;
            mask_r  <= '0;
            state_r <= S_WALK;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_WALK: begin
          if (!row_end) begin
            mask_r <= mask_full;
            x_r    <= x_r + 1'b1;
          end else begin
            out_valid_r         <= 1'b1;
            out_r.row_y         <= y_r;
            out_r.span_left     <= box_r.min_x;
            out_r.coverage_mask <= mask_full;
            out_r.pixel_color   <= color_r;
            out_r.last_row      <= (y_r == box_r.max_y);
            mask_r              <= '0;
            x_r                 <= box_r.min_x;
            if (y_r == box_r.max_y) begin
              state_r <= S_IDLE;
            end else begin
              y_r <= y_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/triangle_edge_rasterizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     start, busy            in_data   (in_t: three vertices, fill color)
// result    out_valid (strobe)     out_data  (out_t: row, left x, mask, color, last)
//
// A triangle is taken when start is high and busy is low. After the accepting edge,
// setup computes the bounding box, then one multiply and one subtract per edge on
// the shared edge unit, then the walk tests one pixel per cycle: busy stays high
// through the whole setup and walk of a W by H box. With start held, the next triangle
// is taken once busy falls, never while one is in flight. Each row's
// result shows on out_valid for one cycle right after the row's last pixel; the
// receiver cannot stall it. Reset is synchronous, active low, and returns the
// sequencer to idle with no result pending.

module triangle_edge_rasterizer_unit
  import ter_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_t      out_data
);

  edge_ctl_t ctl;
  tri_t      verts;
  box_t      box;
  logic      covered;

  // Row sequencer, bounding box and result register.
  ter_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .covered   (covered),
    .busy      (busy),
    .ctl       (ctl),
    .verts     (verts),
    .box       (box),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Shared edge-function arithmetic.
  ter_edge_unit u_edge (
    .clk     (clk),
    .ctl     (ctl),
    .verts   (verts),
    .box     (box),
    .covered (covered)
  );

`ifndef SYNTH
  // The final row of a triangle frees the block; any other row leaves it busy.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_row |-> !busy)
    else $error("last row did not release the block");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |-> busy)
    else $error("block idle before the last row");

  // A new triangle starts with setup, so no row can follow immediately.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted transaction did not start setup");

  // Back-to-back rows of one triangle advance by one.
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_data.last_row) |->
      out_data.row_y == COORD_W'($past(out_data.row_y) + 1'b1))
    else $error("row sequence broken");
`endif

endmodule

`default_nettype wire

// File: tb/ter_row_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the rasterizer. Every accepted triangle is expanded
// into the rows it must produce, and every result strobe is compared with the
// oldest row still due.
module ter_row_checker
  import ter_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   mismatch_count,
  output int   rows_outstanding
);

  out_t rows_due[$];
  int   mismatches;
  int   rows_left;

  assign mismatch_count   = mismatches;
  assign rows_outstanding = rows_left;

  // Coordinates past the tile saturate to its last pixel.
  function automatic int tile_coord(input logic [COORD_W-1:0] v);
    int c;
    c = int'(v);
    if (c > TILE_SIZE - 1) begin
      c = TILE_SIZE - 1;
    end
    return c;
  endfunction

  // Cross product of the edge (x0,y0)->(x1,y1) with the vector to the pixel.
  function automatic int edge_cross(input int x0, input int y0, input int x1,
                                    input int y1, input int px, input int py);
    return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
  endfunction

  // Expand one triangle into its bounding-box rows and queue them.
  task automatic rasterize(input in_t triangle);
    int   vx[3];
    int   vy[3];
    int   min_x, max_x, min_y, max_y;
    int   e0, e1, e2;
    out_t row;
    vx[0] = tile_coord(triangle.ax);
    vy[0] = tile_coord(triangle.ay);
    vx[1] = tile_coord(triangle.bx);
    vy[1] = tile_coord(triangle.by_coord);
    vx[2] = tile_coord(triangle.cx);
    vy[2] = tile_coord(triangle.cy);
    min_x = vx[0];
    max_x = vx[0];
    min_y = vy[0];
    max_y = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < min_x) min_x = vx[i];
      if (vx[i] > max_x) max_x = vx[i];
      if (vy[i] < min_y) min_y = vy[i];
      if (vy[i] > max_y) max_y = vy[i];
    end
    for (int y = min_y; y <= max_y; y++) begin
      row.row_y         = COORD_W'(y);
      row.span_left     = COORD_W'(min_x);
      row.coverage_mask = '0;
      row.pixel_color   = triangle.fill_color;
      row.last_row      = (y == max_y);
      // A pixel is inside when all edges agree in sign, a zero value matching either sign.
      for (int x = min_x; x <= max_x; x++) begin
        e0 = edge_cross(vx[0], vy[0], vx[1], vy[1], x, y);
        e1 = edge_cross(vx[1], vy[1], vx[2], vy[2], x, y);
        e2 = edge_cross(vx[2], vy[2], vx[0], vy[0], x, y);
        if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0)) begin
          row.coverage_mask[x - min_x] = 1'b1;
        end
      end
      rows_due.push_back(row);
    end
  endtask

  task automatic report_field(input string field, input logic [MASK_W-1:0] want_v,
                              input logic [MASK_W-1:0] got_v);
    mismatches++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, field, want_v, got_v);
  endtask

  // Predict on each accepted triangle, check each result transaction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (start && !busy) begin
        rasterize(in_data);
      end
      if (out_valid) begin
        if (rows_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected row: expected none, got %h", $time, out_data);
        end else begin
          want = rows_due.pop_front();
          if (out_data.row_y !== want.row_y) begin
            report_field("row_y", want.row_y, out_data.row_y);
          end
          if (out_data.span_left !== want.span_left) begin
            report_field("span_left", want.span_left, out_data.span_left);
          end
          if (out_data.coverage_mask !== want.coverage_mask) begin
            report_field("coverage_mask", want.coverage_mask, out_data.coverage_mask);
          end
          if (out_data.pixel_color !== want.pixel_color) begin
            report_field("pixel_color", want.pixel_color, out_data.pixel_color);
          end
          if (out_data.last_row !== want.last_row) begin
            report_field("last_row", want.last_row, out_data.last_row);
          end
        end
      end
    end
    rows_left <= rows_due.size();
  end

endmodule

// File: tb/tb_triangle_edge_rasterizer_unit.sv
`timescale 1ns / 1ps

module tb_triangle_edge_rasterizer_unit;
  import ter_pkg::*;

  // Even a full-width row is walked well within this limit, so this many silent cycles means a hang.
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 50;
  localparam int RANDOM_TRIANGLES = 120;

  logic clk;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;
  int   mismatch_count;
  int   rows_outstanding;
  int   quiet_cycles = 0;

  triangle_edge_rasterizer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  ter_row_checker row_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .rows_outstanding(rows_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_t make_corner(input int x0, input int y0, input int x1,
                                      input int y1, input int x2, input int y2,
                                      input logic [COLOR_W-1:0] color);
    in_t t;
    t.ax         = COORD_W'(x0);
    t.ay         = COORD_W'(y0);
    t.bx         = COORD_W'(x1);
    t.by_coord   = COORD_W'(y1);
    t.cx         = COORD_W'(x2);
    t.cy         = COORD_W'(y2);
    t.fill_color = color;
    return t;
  endfunction

  // Mostly small boxes anywhere in the tile, a few mid-size and full-tile ones,
  // and a share of degenerate shapes.
  function automatic in_t make_triangle();
    in_t t;
    int  span, org_x, org_y, d, pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      span = $urandom_range(0, 12);
    end else if (pick < 95) begin
      span = $urandom_range(13, 40);
    end else begin
      span = TILE_SIZE - 1;
    end
    org_x        = $urandom_range(0, TILE_SIZE - 1 - span);
    org_y        = $urandom_range(0, TILE_SIZE - 1 - span);
    t.ax         = COORD_W'(org_x + $urandom_range(0, span));
    t.ay         = COORD_W'(org_y + $urandom_range(0, span));
    t.bx         = COORD_W'(org_x + $urandom_range(0, span));
    t.by_coord   = COORD_W'(org_y + $urandom_range(0, span));
    t.cx         = COORD_W'(org_x + $urandom_range(0, span));
    t.cy         = COORD_W'(org_y + $urandom_range(0, span));
    t.fill_color = $urandom();
    case ($urandom_range(0, 19))
      0: begin
        t.bx       = t.ax;
        t.by_coord = t.ay;
        t.cx       = t.ax;
        t.cy       = t.ay;
      end
      1: begin
        t.by_coord = t.ay;
        t.cy       = t.ay;
      end
      2: begin
        t.bx = t.ax;
        t.cx = t.ax;
      end
      3: begin
        d          = $urandom_range(0, span / 2);
        t.ax       = COORD_W'(org_x);
        t.ay       = COORD_W'(org_y);
        t.bx       = COORD_W'(org_x + d);
        t.by_coord = COORD_W'(org_y + d);
        t.cx       = COORD_W'(org_x + 2 * d);
        t.cy       = COORD_W'(org_y + 2 * d);
      end
      4: begin
        t.cx = t.ax;
        t.cy = t.ay;
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  // Hold start until the block takes the transaction.
  task automatic send_triangle(input in_t triangle);
    start   <= 1'b1;
    in_data <= triangle;
    do @(posedge clk); while (busy);
  endtask

  // Random idle cycles with noise on the data lines.
  task automatic idle_gap();
    while ($urandom_range(0, 99) < 17) begin
      start   <= 1'b0;
      in_data <= make_triangle();
      @(posedge clk);
    end
  endtask

  // Hold off the next triangle until every row already due has come out.
  task automatic drain_rows();
    start <= 1'b0;
    @(posedge clk);
    while (rows_outstanding != 0) @(posedge clk);
  endtask

  // Stimulus: corner cases first, then random triangles.
  initial begin
    in_t corner_cases[$];
    corner_cases.push_back(make_corner(0, 0, 63, 0, 0, 63, 32'h0000_0000));
    corner_cases.push_back(make_corner(0, 0, 0, 63, 63, 0, 32'hFFFF_FFFF));
    corner_cases.push_back(make_corner(63, 63, 0, 63, 63, 0, 32'h1234_5678));
    corner_cases.push_back(make_corner(0, 0, 0, 0, 0, 0, 32'h8000_0001));
    corner_cases.push_back(make_corner(63, 63, 63, 63, 63, 63, 32'h7FFF_FFFE));
    corner_cases.push_back(make_corner(21, 42, 21, 42, 21, 42, 32'hA5A5_A5A5));
    corner_cases.push_back(make_corner(0, 10, 63, 10, 30, 10, 32'h5A5A_5A5A));
    corner_cases.push_back(make_corner(5, 0, 5, 63, 5, 20, 32'hDEAD_BEEF));
    corner_cases.push_back(make_corner(0, 0, 63, 63, 31, 31, 32'h0F0F_0F0F));
    corner_cases.push_back(make_corner(0, 63, 63, 0, 32, 31, 32'hF0F0_F0F0));
    corner_cases.push_back(make_corner(0, 0, 2, 1, 62, 31, 32'h3333_CCCC));
    corner_cases.push_back(make_corner(10, 10, 10, 10, 20, 30, 32'hCAFE_F00D));
    corner_cases.push_back(make_corner(0, 0, 63, 1, 62, 1, 32'h0000_FFFF));
    corner_cases.push_back(make_corner(3, 4, 7, 4, 3, 8, 32'hFFFF_0000));
    corner_cases.push_back(make_corner(3, 8, 7, 4, 3, 4, 32'h0101_0101));
    corner_cases.push_back(make_corner(0, 30, 63, 31, 32, 33, 32'hFEDC_BA98));
    corner_cases.push_back(make_corner(0, 7, 63, 7, 0, 8, 32'h2468_ACE0));
    corner_cases.push_back(make_corner(40, 0, 41, 63, 40, 63, 32'h1357_9BDF));
    corner_cases.push_back(make_corner(42, 21, 21, 42, 63, 63, 32'h5555_AAAA));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_cases[i]) begin
      send_triangle(corner_cases[i]);
      idle_gap();
    end
    drain_rows();

    // Back-to-back transactions in the middle stretch, one full drain later on.
    for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
      send_triangle(make_triangle());
      if (n == 90) begin
        drain_rows();
      end else if (n < 40 || n >= 80) begin
        idle_gap();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (rows_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && rows_outstanding == 0) begin
      $display("tb_triangle_edge_rasterizer_unit: PASS");
    end else begin
      $display("tb_triangle_edge_rasterizer_unit: FAIL");
    end
    $finish;
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_triangle_edge_rasterizer_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
